// ===== hdl/sprite_quad_vertex_setup_unit_macros.svh =====
// Assertion macros used by the vertex setup unit.
`ifndef SPRITE_QUAD_VERTEX_SETUP_UNIT_MACROS_SVH
`define SPRITE_QUAD_VERTEX_SETUP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SQVS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define SQVS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SQVS_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define SQVS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hdl/sqvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sqvs_pkg;

  localparam int REG_W = 14;
  localparam int QUO_W = 16;
  localparam int NUM_W = 32;
  localparam int REM_W = 30;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = QUO_W / DIV_BITS_PER_STAGE;
  localparam int DIV_LAT = DIV_STAGES + 1;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int VERTS = 6;
  localparam logic [2:0] LAST_VTX = 3'(VERTS - 1);

  localparam logic [REG_W-1:0] VP_W_RST  = 14'd1920;
  localparam logic [REG_W-1:0] VP_H_RST  = 14'd1080;
  localparam logic [REG_W-1:0] TEX_W_RST = 14'd256;
  localparam logic [REG_W-1:0] TEX_H_RST = 14'd256;

  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [30:0] C5 = 31'd3864;
  localparam logic [30:0] HORNER_C [5] = '{31'd172272, 31'd5026995, 31'd85569306,
                                           31'd693598668, 31'd1686629713};

  localparam logic [15:0] SAT_POS = 16'h7FFF;
  localparam logic [15:0] SAT_NEG = 16'h8000;
  localparam logic [15:0] SAT_U   = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_VP_W  = 2'd0,
    REG_VP_H  = 2'd1,
    REG_TEX_W = 2'd2,
    REG_TEX_H = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic [15:0] dest_w;
    logic [15:0] dest_h;
    logic [31:0] color;
    logic [15:0] turn;
    logic [15:0] src_x;
    logic [15:0] src_y;
    logic [15:0] src_w;
    logic [15:0] src_h;
  } item_t;

  typedef struct packed {
    logic [31:0] color;
    logic        last;
    logic        oxn;
    logic        oyn;
    logic [15:0] dw;
    logic [15:0] dh;
    logic signed [17:0] cx;
    logic signed [17:0] cy;
    logic [REG_W-1:0] vw;
    logic [REG_W-1:0] vh;
    logic [REG_W-1:0] tw;
    logic [REG_W-1:0] th;
    logic [27:0] nu;
    logic [27:0] nv;
    logic [30:0] xs;
    logic [30:0] xc;
    logic        sn;
    logic        cn;
    logic [30:0] x2s;
    logic [30:0] x2c;
    logic [30:0] ts;
    logic [30:0] tc;
    logic signed [31:0] sin_v;
    logic signed [31:0] cos_v;
    logic signed [47:0] pcx;
    logic signed [47:0] psx;
    logic signed [47:0] pcy;
    logic signed [47:0] psy;
    logic signed [49:0] bx;
    logic signed [49:0] by;
    logic signed [NUM_W-1:0] numx;
    logic signed [NUM_W-1:0] numy;
  } pipe_t;

  // Vertex order 0,1,2,2,1,3 of the two triangles.
  function automatic logic [1:0] corner_of(logic [2:0] k);
    logic [1:0] c;
    unique case (k)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd2;
      3'd4:    c = 2'd1;
      default: c = 2'd3;
    endcase
    return c;
  endfunction

  // Folds a turn phase into a quarter-wave argument; bit 31 is the sign.
  function automatic logic [31:0] fold_phase(logic [31:0] p);
    logic [30:0] x;
    x = p[30] ? (ONE_Q30 - 31'(p[29:0])) : 31'(p[29:0]);
    return {p[31], x};
  endfunction

  function automatic logic [30:0] horner(logic [30:0] c, logic [30:0] x2, logic [30:0] t);
    logic [61:0] p;
    p = 62'(x2) * 62'(t);
    return c - 31'(p >> 30);
  endfunction

  function automatic logic signed [31:0] sine_out(logic [30:0] x, logic [30:0] t,
                                                  logic neg);
    logic [61:0] p;
    logic [31:0] v;
    p = 62'(x) * 62'(t);
    v = 32'(p >> 30);
    if (v > 32'(ONE_Q30)) v = 32'(ONE_Q30);
    return neg ? -$signed(v) : $signed(v);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sqvs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider with range detection. The quotient is valid
// only when neither lo_o (negative numerator) nor hi_o (quotient overflow) is set.
module sqvs_div
  import sqvs_pkg::*;
(
  input  logic                    clk_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [REG_W-1:0]        den_i,
  output logic [QUO_W-1:0]        quo_o,
  output logic                    lo_o,
  output logic                    hi_o
);

  logic [REM_W-1:0] rem_q [DIV_LAT];
  logic [REM_W-1:0] rem_d [DIV_LAT];
  logic [QUO_W-1:0] quo_q [DIV_LAT];
  logic [QUO_W-1:0] quo_d [DIV_LAT];
  logic [REG_W-1:0] den_q [DIV_LAT];
  logic [REG_W-1:0] den_d [DIV_LAT];
  logic             lo_q  [DIV_LAT];
  logic             lo_d  [DIV_LAT];
  logic             hi_q  [DIV_LAT];
  logic             hi_d  [DIV_LAT];

  always_comb begin
    logic [NUM_W-1:0] lim;
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] sh;
    logic [QUO_W-1:0] q;
    lim = NUM_W'(den_i) << QUO_W;
    rem_d[0] = num_i[REM_W-1:0];
    quo_d[0] = '0;
    den_d[0] = den_i;
    lo_d[0]  = num_i[NUM_W-1];
    hi_d[0]  = !num_i[NUM_W-1] && ($unsigned(num_i) >= lim);
    for (int s = 1; s < DIV_LAT; s++) begin
      r = rem_q[s-1];
      q = quo_q[s-1];
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
        sh = REM_W'(den_q[s-1]) << (QUO_W - 1 - DIV_BITS_PER_STAGE * (s - 1) - b);
        if (r >= sh) begin
          r = r - sh;
          q[QUO_W - 1 - DIV_BITS_PER_STAGE * (s - 1) - b] = 1'b1;
        end
      end
      rem_d[s] = r;
      quo_d[s] = q;
      den_d[s] = den_q[s-1];
      lo_d[s]  = lo_q[s-1];
      hi_d[s]  = hi_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
  end

  assign quo_o = quo_q[DIV_LAT-1];
  assign lo_o  = lo_q[DIV_LAT-1];
  assign hi_o  = hi_q[DIV_LAT-1];

endmodule
`default_nettype wire

// ===== hdl/sprite_quad_vertex_setup_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Rotated sprite quad vertex setup.
// A sprite is offered on the dest, color, angle and src ports with start_i;
// it is taken at a clock edge where start_i is high and busy_o is low.
// Each sprite gives six vertices (triangles 0,1,2 and 2,1,3) on the result
// ports, one per cycle with valid_o high, the sixth with last_vertex_o set.
// The first vertex passes the sprite register, compute pipeline, divider stages
// and output register; the six follow in consecutive cycles. A sprite expands into
// one vertex per cycle through the pipeline, so sprites are taken back to back.
// The pipeline is 11 stages of sine polynomial, rotation and offset math,
// then 9 stages of restoring division by the viewport and texture sizes.
// The size registers are written on the cfg channel, which is always ready;
// the user must see they are written only while no sprite is in flight (unchecked).
// Reset clears the pipeline valid bits and loads 1920x1080 viewport and
// 256x256 texture sizes. The receiver cannot stall the result channel.
`include "sprite_quad_vertex_setup_unit_macros.svh"
module sprite_quad_vertex_setup_unit
  import sqvs_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] dest_x_i,
  input  logic signed [15:0] dest_y_i,
  input  logic [15:0]        dest_w_i,
  input  logic [15:0]        dest_h_i,
  input  logic [31:0]        color_rgba_i,
  input  logic [15:0]        turn_angle_i,
  input  logic [15:0]        src_x_i,
  input  logic [15:0]        src_y_i,
  input  logic [15:0]        src_w_i,
  input  logic [15:0]        src_h_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [REG_W-1:0]   cfg_data_i,
  output logic               valid_o,
  output logic signed [15:0] ndc_x_o,
  output logic signed [15:0] ndc_y_o,
  output logic [15:0]        tex_u_o,
  output logic [15:0]        tex_v_o,
  output logic [31:0]        vertex_color_o,
  output logic               last_vertex_o
);

  localparam int NS = 11;
  localparam logic [31:0] AngMask = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;

  logic [REG_W-1:0] vw_q, vh_q, tw_q, th_q;
  item_t            item_q;
  logic             active_q;
  logic [2:0]       k_q;
  logic             accept;

  pipe_t head_d;
  pipe_t pipe_q [NS];
  pipe_t pipe_d [NS];
  logic  pvld_q [NS];

  logic [31:0] color_q [DIV_LAT];
  logic        last_q  [DIV_LAT];
  logic        dvld_q  [DIV_LAT];

  logic [QUO_W-1:0] qx, qy, qu, qv;
  logic lox, hix, loy, hiy, lou, hiu, lov, hiv;

  logic               valid_q;
  logic signed [15:0] ndc_x_q, ndc_y_q;
  logic [15:0]        tex_u_q, tex_v_q;
  logic [31:0]        color_out_q;
  logic               last_out_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o = active_q && (k_q != LAST_VTX);
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q <= VP_W_RST;
      vh_q <= VP_H_RST;
      tw_q <= TEX_W_RST;
      th_q <= TEX_H_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_VP_W:  vw_q <= cfg_data_i;
        REG_VP_H:  vh_q <= cfg_data_i;
        REG_TEX_W: tw_q <= cfg_data_i;
        REG_TEX_H: th_q <= cfg_data_i;
      endcase
    end
  end

  // Vertex sequencer; the sprite register is loaded in the block below.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      k_q      <= '0;
    end else if (accept) begin
      active_q <= 1'b1;
      k_q      <= '0;
    end else if (active_q) begin
      if (k_q == LAST_VTX) begin
        active_q <= 1'b0;
      end else begin
        k_q <= k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{dest_x: dest_x_i, dest_y: dest_y_i, dest_w: dest_w_i,
                  dest_h: dest_h_i, color: color_rgba_i, turn: turn_angle_i,
                  src_x: src_x_i, src_y: src_y_i, src_w: src_w_i, src_h: src_h_i};
    end
  end

  always_comb begin
    logic [1:0]  corner;
    logic [31:0] phase;
    logic [31:0] fs, fc;
    logic [REG_W-1:0] vw, vh, tw, th;
    logic [16:0] au, av;
    corner = corner_of(k_q);
    phase  = (32'(item_q.turn) & AngMask) << (32 - ANGLE_BITS);
    fs = fold_phase(phase);
    fc = fold_phase(phase + QuarterTurn);
    // A size register holding zero acts as one.
    vw = (vw_q == '0) ? REG_W'(1) : vw_q;
    vh = (vh_q == '0) ? REG_W'(1) : vh_q;
    tw = (tw_q == '0) ? REG_W'(1) : tw_q;
    th = (th_q == '0) ? REG_W'(1) : th_q;
    au = corner[0] ? (17'(item_q.src_x) + 17'(item_q.src_w)) : 17'(item_q.src_x);
    av = corner[1] ? (17'(item_q.src_y) + 17'(item_q.src_h)) : 17'(item_q.src_y);

    head_d = '0;
    head_d.color = item_q.color;
    head_d.last  = (k_q == LAST_VTX);
    head_d.oxn   = !corner[0];
    head_d.oyn   = !corner[1];
    head_d.dw    = item_q.dest_w;
    head_d.dh    = item_q.dest_h;
    head_d.cx    = $signed({item_q.dest_x[15], item_q.dest_x, 1'b0})
                 + $signed({2'b00, item_q.dest_w});
    head_d.cy    = $signed({item_q.dest_y[15], item_q.dest_y, 1'b0})
                 + $signed({2'b00, item_q.dest_h});
    head_d.vw = vw;
    head_d.vh = vh;
    head_d.tw = tw;
    head_d.th = th;
    head_d.nu = {1'b0, au, 10'b0} + 28'(tw >> 1);
    head_d.nv = {1'b0, av, 10'b0} + 28'(th >> 1);
    head_d.xs = fs[30:0];
    head_d.sn = fs[31];
    head_d.xc = fc[30:0];
    head_d.cn = fc[31];
  end

  // Compute stages: square, five Horner steps, final multiply and sign,
  // rotation products, sums, then the biased division numerators.
  always_comb begin
    logic signed [52:0] offx, offy, ax, ay;
    pipe_d[0] = head_d;
    for (int i = 1; i < NS; i++) begin
      pipe_d[i] = pipe_q[i-1];
    end
    pipe_d[1].x2s = 31'((62'(pipe_q[0].xs) * 62'(pipe_q[0].xs)) >> 30);
    pipe_d[1].x2c = 31'((62'(pipe_q[0].xc) * 62'(pipe_q[0].xc)) >> 30);
    pipe_d[1].ts  = C5;
    pipe_d[1].tc  = C5;
    for (int i = 2; i < 7; i++) begin
      pipe_d[i].ts = horner(HORNER_C[i-2], pipe_q[i-1].x2s, pipe_q[i-1].ts);
      pipe_d[i].tc = horner(HORNER_C[i-2], pipe_q[i-1].x2c, pipe_q[i-1].tc);
    end
    pipe_d[7].sin_v = sine_out(pipe_q[6].xs, pipe_q[6].ts, pipe_q[6].sn);
    pipe_d[7].cos_v = sine_out(pipe_q[6].xc, pipe_q[6].tc, pipe_q[6].cn);

    pipe_d[8].pcx = 48'(pipe_q[7].cos_v * $signed({1'b0, pipe_q[7].dw}));
    pipe_d[8].psx = 48'(pipe_q[7].sin_v * $signed({1'b0, pipe_q[7].dw}));
    pipe_d[8].pcy = 48'(pipe_q[7].cos_v * $signed({1'b0, pipe_q[7].dh}));
    pipe_d[8].psy = 48'(pipe_q[7].sin_v * $signed({1'b0, pipe_q[7].dh}));

    pipe_d[9].bx = (50'(pipe_q[8].cx) <<< 30)
                 + (pipe_q[8].oxn ? -50'(pipe_q[8].pcx) : 50'(pipe_q[8].pcx))
                 - (pipe_q[8].oyn ? -50'(pipe_q[8].psy) : 50'(pipe_q[8].psy));
    pipe_d[9].by = (50'(pipe_q[8].cy) <<< 30)
                 + (pipe_q[8].oxn ? -50'(pipe_q[8].psx) : 50'(pipe_q[8].psx))
                 + (pipe_q[8].oyn ? -50'(pipe_q[8].pcy) : 50'(pipe_q[8].pcy));

    // Rounding half plus a bias that moves the valid quotient range to
    // [0, 65535]: 16384*W for x and 16383*H for y.
    offx = ($signed({39'b0, pipe_q[9].vw}) <<< 20) + ($signed({39'b0, pipe_q[9].vw}) <<< 35);
    offy = ($signed({39'b0, pipe_q[9].vh}) <<< 20) + ($signed({39'b0, pipe_q[9].vh}) <<< 35)
         - ($signed({39'b0, pipe_q[9].vh}) <<< 21);
    ax = (53'(pipe_q[9].bx) <<< 1) + offx;
    ay = (53'(pipe_q[9].by) <<< 1) + offy;
    pipe_d[10].numx = NUM_W'(ax >>> 21);
    pipe_d[10].numy = NUM_W'(ay >>> 21);
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) pvld_q[i] <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) dvld_q[i] <= 1'b0;
    end else begin
      pvld_q[0] <= active_q;
      for (int i = 1; i < NS; i++) pvld_q[i] <= pvld_q[i-1];
      dvld_q[0] <= pvld_q[NS-1];
      for (int i = 1; i < DIV_LAT; i++) dvld_q[i] <= dvld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    color_q[0] <= pipe_q[NS-1].color;
    last_q[0]  <= pipe_q[NS-1].last;
    for (int i = 1; i < DIV_LAT; i++) begin
      color_q[i] <= color_q[i-1];
      last_q[i]  <= last_q[i-1];
    end
  end

  sqvs_div u_div_x (
    .clk_i (clk_i),
    .num_i (pipe_q[NS-1].numx),
    .den_i (pipe_q[NS-1].vw),
    .quo_o (qx),
    .lo_o  (lox),
    .hi_o  (hix)
  );

  sqvs_div u_div_y (
    .clk_i (clk_i),
    .num_i (pipe_q[NS-1].numy),
    .den_i (pipe_q[NS-1].vh),
    .quo_o (qy),
    .lo_o  (loy),
    .hi_o  (hiy)
  );

  sqvs_div u_div_u (
    .clk_i (clk_i),
    .num_i ($signed(NUM_W'(pipe_q[NS-1].nu))),
    .den_i (pipe_q[NS-1].tw),
    .quo_o (qu),
    .lo_o  (lou),
    .hi_o  (hiu)
  );

  sqvs_div u_div_v (
    .clk_i (clk_i),
    .num_i ($signed(NUM_W'(pipe_q[NS-1].nv))),
    .den_i (pipe_q[NS-1].th),
    .quo_o (qv),
    .lo_o  (lov),
    .hi_o  (hiv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      last_out_q <= 1'b0;
    end else begin
      valid_q    <= dvld_q[DIV_LAT-1];
      last_out_q <= dvld_q[DIV_LAT-1] && last_q[DIV_LAT-1];
    end
  end

  // The biased quotient maps to the result by flipping the sign bit for x
  // and inverting the low bits for y, where the axis points up.
  always_ff @(posedge clk_i) begin
    color_out_q <= color_q[DIV_LAT-1];
    if (lox) ndc_x_q <= SAT_NEG;
    else if (hix) ndc_x_q <= SAT_POS;
    else ndc_x_q <= {~qx[QUO_W-1], qx[QUO_W-2:0]};
    if (loy) ndc_y_q <= SAT_POS;
    else if (hiy) ndc_y_q <= SAT_NEG;
    else ndc_y_q <= {qy[QUO_W-1], ~qy[QUO_W-2:0]};
    tex_u_q <= (lou || hiu) ? SAT_U : qu;
    tex_v_q <= (lov || hiv) ? SAT_U : qv;
  end

  assign valid_o        = valid_q;
  assign ndc_x_o        = ndc_x_q;
  assign ndc_y_o        = ndc_y_q;
  assign tex_u_o        = tex_u_q;
  assign tex_v_o        = tex_v_q;
  assign vertex_color_o = color_out_q;
  assign last_vertex_o  = last_out_q;

  `SQVS_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, accept, active_q && (k_q == '0), "accepted sprite did not start at vertex zero")
  `SQVS_ASSERT_NEXT(a_seq_ends, clk_i, rst_ni, active_q && (k_q == LAST_VTX) && !start_i, !active_q, "sequencer ran past the sixth vertex")
  `SQVS_ASSERT_IMP(a_last_valid, clk_i, rst_ni, last_vertex_o, valid_o, "last vertex flag without a result")

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import sqvs_pkg::*;

  typedef struct {
    logic signed [15:0] ndc_x;
    logic signed [15:0] ndc_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        color;
    logic               last;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [15:0] dest_x_i = '0, dest_y_i = '0;
  logic [15:0] dest_w_i = '0, dest_h_i = '0, turn_angle_i = '0;
  logic [15:0] src_x_i = '0, src_y_i = '0, src_w_i = '0, src_h_i = '0;
  logic [31:0] color_rgba_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = REG_VP_W;
  logic [REG_W-1:0] cfg_data_i = '0;
  logic valid_o;
  logic signed [15:0] ndc_x_o, ndc_y_o;
  logic [15:0] tex_u_o, tex_v_o;
  logic [31:0] vertex_color_o;
  logic last_vertex_o;

  item_t   sprite_q[$];
  vertex_t vertex_q[$];
  item_t   cur_sprite;
  int      idle_pct = 0;
  bit      hold_off = 1'b0;
  int      errors = 0;
  int      sprites_taken = 0;
  int      vertices_seen = 0;
  logic [REG_W-1:0] vp_w = VP_W_RST, vp_h = VP_H_RST, tx_w = TEX_W_RST, tx_h = TEX_H_RST;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sprite_quad_vertex_setup_unit i_dut (.*);

  function automatic void add_sprite(item_t it);
    sprite_q = {sprite_q, it};
  endfunction

  function automatic longint qsine(longint unsigned x);
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t = 64'd3864;
    t = 64'd172272 - ((x2 * t) >> 30);
    t = 64'd5026995 - ((x2 * t) >> 30);
    t = 64'd85569306 - ((x2 * t) >> 30);
    t = 64'd693598668 - ((x2 * t) >> 30);
    t = 64'd1686629713 - ((x2 * t) >> 30);
    t = (x * t) >> 30;
    return (t > 64'd1073741824) ? 64'sd1073741824 : longint'(t);
  endfunction

  function automatic longint turn_sin(logic [31:0] p);
    longint mag;
    mag = p[30] ? qsine(64'd1073741824 - p[29:0]) : qsine(p[29:0]);
    return p[31] ? -mag : mag;
  endfunction

  // Rounds n/d to nearest with halves going up, for d > 0.
  function automatic longint round_div(longint n, longint d);
    longint m, d2;
    m = n * 2 + d;
    d2 = d * 2;
    if (m >= 0) return m / d2;
    return -((-m + d2 - 1) / d2);
  endfunction

  function automatic logic [15:0] sat_s16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] tex_coord(longint unsigned t, logic [REG_W-1:0] size);
    longint unsigned s, v;
    s = (size == 0) ? 1 : size;
    v = (t * 2048 + s) / (2 * s);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic predict_vertices(item_t it);
    logic [31:0] p;
    longint s, c, vw, vh, dw, dh, ccx, ccy, ox, oy, xx, yy;
    logic [15:0] u[2], v[2], nx[4], ny[4];
    int corner;
    vertex_t vx;
    p = {it.turn, 16'h0};
    s = turn_sin(p);
    c = turn_sin(p + 32'h4000_0000);
    vw = (vp_w == 0) ? 1 : vp_w;
    vh = (vp_h == 0) ? 1 : vp_h;
    dw = it.dest_w;
    dh = it.dest_h;
    ccx = (2 * longint'(it.dest_x) + dw) * 64'sd1073741824;
    ccy = (2 * longint'(it.dest_y) + dh) * 64'sd1073741824;
    u[0] = tex_coord(it.src_x, tx_w);
    u[1] = tex_coord(64'(it.src_x) + it.src_w, tx_w);
    v[0] = tex_coord(it.src_y, tx_h);
    v[1] = tex_coord(64'(it.src_y) + it.src_h, tx_h);
    for (int k = 0; k < 4; k++) begin
      ox = k[0] ? dw : -dw;
      oy = k[1] ? dh : -dh;
      xx = ccx + c * ox - s * oy;
      yy = ccy + s * ox + c * oy;
      nx[k] = sat_s16(round_div(xx, vw * 1048576) - 16384);
      ny[k] = sat_s16(16384 - round_div(yy, vh * 1048576));
    end
    for (int k = 0; k < 6; k++) begin
      corner = (k == 0) ? 0 : (k == 1 || k == 4) ? 1 : (k == 5) ? 3 : 2;
      vx.ndc_x = nx[corner];
      vx.ndc_y = ny[corner];
      vx.tex_u = u[corner & 1];
      vx.tex_v = v[corner >> 1];
      vx.color = it.color;
      vx.last = (k == 5);
      vertex_q = {vertex_q, vx};
    end
  endtask

  // Driver: an accepted sprite is predicted, then the next one may be offered.
  always @(posedge clk_i) begin
    item_t it;
    bit take;
    take = 1'b0;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_vertices(cur_sprite);
        sprites_taken++;
        take = 1'b1;
      end
      if (!start_i || take) begin
        if (sprite_q.size() > 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
          it = sprite_q.pop_front();
          cur_sprite <= it;
          dest_x_i <= it.dest_x;
          dest_y_i <= it.dest_y;
          dest_w_i <= it.dest_w;
          dest_h_i <= it.dest_h;
          color_rgba_i <= it.color;
          turn_angle_i <= it.turn;
          src_x_i <= it.src_x;
          src_y_i <= it.src_y;
          src_w_i <= it.src_w;
          src_h_i <= it.src_h;
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every vertex strobe is one transaction checked against the oldest prediction.
  always @(posedge clk_i) begin
    vertex_t ex;
    if (rst_ni && valid_o) begin
      vertices_seen++;
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected vertex ndc_x=%0d ndc_y=%0d", $time, ndc_x_o, ndc_y_o);
        errors++;
      end else begin
        ex = vertex_q.pop_front();
        if (ndc_x_o !== ex.ndc_x) begin
          $display("%0t: ndc_x expected %0d actual %0d", $time, ex.ndc_x, ndc_x_o);
          errors++;
        end
        if (ndc_y_o !== ex.ndc_y) begin
          $display("%0t: ndc_y expected %0d actual %0d", $time, ex.ndc_y, ndc_y_o);
          errors++;
        end
        if (tex_u_o !== ex.tex_u) begin
          $display("%0t: tex_u expected %0d actual %0d", $time, ex.tex_u, tex_u_o);
          errors++;
        end
        if (tex_v_o !== ex.tex_v) begin
          $display("%0t: tex_v expected %0d actual %0d", $time, ex.tex_v, tex_v_o);
          errors++;
        end
        if (vertex_color_o !== ex.color) begin
          $display("%0t: vertex_color expected %h actual %h", $time, ex.color, vertex_color_o);
          errors++;
        end
        if (last_vertex_o !== ex.last) begin
          $display("%0t: last_vertex expected %b actual %b", $time, ex.last, last_vertex_o);
          errors++;
        end
      end
    end
  end

  function automatic item_t make_sprite(bit full);
    item_t it;
    it.dest_x = 16'($urandom());
    it.dest_y = 16'($urandom());
    it.dest_w = full ? 16'($urandom()) : 16'($urandom_range(0, 4095));
    it.dest_h = full ? 16'($urandom()) : 16'($urandom_range(0, 4095));
    it.color = $urandom();
    it.turn = 16'($urandom());
    it.src_x = full ? 16'($urandom()) : 16'($urandom_range(0, 4095));
    it.src_y = full ? 16'($urandom()) : 16'($urandom_range(0, 4095));
    it.src_w = full ? 16'($urandom()) : 16'($urandom_range(0, 4095));
    it.src_h = full ? 16'($urandom()) : 16'($urandom_range(0, 4095));
    return it;
  endfunction

  function automatic item_t sprite_of(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                                      logic [15:0] h, logic [15:0] turn, logic [15:0] src);
    item_t it;
    it = '{x, y, w, h, $urandom(), turn, src, src, w, h};
    return it;
  endfunction

  task automatic drain();
    while (sprite_q.size() > 0 || vertex_q.size() > 0 || start_i) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [REG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_VP_W:  vp_w = val;
      REG_VP_H:  vp_h = val;
      REG_TEX_W: tx_w = val;
      default:   tx_h = val;
    endcase
  endtask

  task automatic write_sizes(logic [REG_W-1:0] w, logic [REG_W-1:0] h,
                             logic [REG_W-1:0] tw, logic [REG_W-1:0] th);
    write_reg(REG_VP_W, w);
    write_reg(REG_VP_H, h);
    write_reg(REG_TEX_W, tw);
    write_reg(REG_TEX_H, th);
  endtask

  initial begin
    int pcts[4];
    pcts = '{0, 64, 13, 0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed sprites under the reset sizes: edges of every field but the color, and the quadrant angles.
    add_sprite(sprite_of(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
    add_sprite(sprite_of(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_sprite(sprite_of(16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h4000, 16'h0010));
    foreach (pcts[i]) begin
      add_sprite(sprite_of(16'h1000, 16'h0800, 16'h0400, 16'h0200,
                           16'(i * 16'h4000), 16'h0100));
      add_sprite(sprite_of(16'h1000, 16'h0800, 16'h0400, 16'h0200,
                           16'(i * 16'h4000 + 1), 16'h0100));
      add_sprite(sprite_of(16'hF000, 16'h0800, 16'h7FFF, 16'h3000,
                           16'(i * 16'h4000 + 16'h2000), 16'h8000));
    end
    add_sprite(sprite_of(16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0001, 16'h0001));
    add_sprite(sprite_of(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h0000));
    drain();
    // Sizes of zero act as one.
    write_sizes(14'd0, 14'd0, 14'd0, 14'd0);
    for (int i = 0; i < 6; i++) add_sprite(make_sprite(i[0]));
    drain();
    write_sizes(14'd1, 14'd1, 14'd1, 14'd1);
    for (int i = 0; i < 6; i++) add_sprite(make_sprite(i[0]));
    drain();
    write_sizes(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
    for (int i = 0; i < 6; i++) add_sprite(make_sprite(1'b1));
    drain();
    // Random phases, each under a size setting and sender idle rate set anew for it.
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) write_sizes(VP_W_RST, VP_H_RST, TEX_W_RST, TEX_H_RST);
      else write_sizes(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)),
                       14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
      idle_pct = pcts[ph];
      for (int i = 0; i < 70; i++) add_sprite(make_sprite($urandom_range(3) == 0));
      if (ph == 2) begin
        // Let half go, then hold the sender until every vertex has come back.
        while (sprite_q.size() > 35) @(posedge clk_i);
        hold_off = 1'b1;
        while (vertex_q.size() > 0) @(posedge clk_i);
        repeat (30) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end
    $display("Covered %0d sprites and %0d vertices over zero, unit, full and random sizes,",
             sprites_taken, vertices_seen);
    $display("with sender idle rates of 0, 13 and 64 percent and one full pipeline drain.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sqvs_pkg.sv
hdl/sqvs_div.sv
hdl/sprite_quad_vertex_setup_unit.sv
bench/testbench.sv
